>>> src/vtgb_pkg.sv
// ----------------------------------------------------------------------------
// vtgb_pkg
// Shared types, constants and helpers of the vector-tile geometry box block.
// ----------------------------------------------------------------------------
package vtgb_pkg;

    localparam int unsigned VTGB_QUEUE_DEPTH = 4;
    localparam int unsigned VTGB_ACC_W       = 35;
    localparam int unsigned VTGB_COORD_W     = 32;
    localparam int unsigned VTGB_CNT_W       = 4;
    localparam logic [VTGB_CNT_W-1:0] VTGB_LAST_VARINT_BYTE = 4'd9;
    localparam logic [VTGB_CNT_W-1:0] VTGB_GATHER_BYTES     = 4'd5;
    localparam logic [7:0] VTGB_PAYLOAD_MASK = 8'h7f;
    localparam logic [7:0] VTGB_CONT_MASK    = 8'h80;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_MOVE_TO = 3'd1,
        CMD_LINE_TO = 3'd2,
        CMD_OTHER3  = 3'd3,
        CMD_OTHER4  = 3'd4,
        CMD_OTHER5  = 3'd5,
        CMD_OTHER6  = 3'd6,
        CMD_OTHER7  = 3'd7
    } cmd_id_t;

    typedef struct packed {
        logic                           is_summary;
        logic signed [VTGB_COORD_W-1:0] vertex_x;
        logic signed [VTGB_COORD_W-1:0] vertex_y;
        logic [VTGB_COORD_W-1:0]        box_width;
        logic [VTGB_COORD_W-1:0]        box_height;
        logic                           any_vertex;
        logic                           last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [VTGB_COORD_W-1:0] unzig(input logic [VTGB_COORD_W-1:0] n);
        unzig = (n >> 1) ^ {VTGB_COORD_W{n[0]}};
    endfunction

endpackage

>>> src/vector_tile_geometry_bbox.sv
// ----------------------------------------------------------------------------
// vector_tile_geometry_bbox
// Decodes a vector-tile geometry byte stream into vertices and a bounding box.
// ----------------------------------------------------------------------------
// Channel   Direction  Item
// s_        in         one buffer byte and its end-of-buffer flag
// m_        out        one vertex or one bounding-box summary
//
// One byte is taken per cycle while s_ready is high; each byte yields zero, one or two items.
// Decoding and the box fold are done in the cycle the byte is accepted and
// the items are written into a small result queue.
// s_ready is high while the queue has room for two items, so stalls on the
// result side hold back input only once fewer than two places are left.
// Synchronous active-low reset clears the decoder state and empties the queue.
// ----------------------------------------------------------------------------
module vector_tile_geometry_bbox
    import vtgb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = VTGB_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_end_of_buffer,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_summary,
    output logic signed [31:0] m_vertex_x,
    output logic signed [31:0] m_vertex_y,
    output logic [31:0]        m_box_width,
    output logic [31:0]        m_box_height,
    output logic               m_any_vertex,
    output logic               m_last
);

    logic    accept;
    logic    pop;
    logic    room;
    push_t   push;
    result_t head;

    assign s_ready = room;
    assign accept  = s_valid && room;
    assign pop     = m_valid && m_ready;

    vtgb_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .end_of_buffer (s_end_of_buffer),
        .push          (push)
    );

    vtgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .room      (room),
        .not_empty (m_valid),
        .head      (head)
    );

    assign m_is_summary = head.is_summary;
    assign m_vertex_x   = head.vertex_x;
    assign m_vertex_y   = head.vertex_y;
    assign m_box_width  = head.box_width;
    assign m_box_height = head.box_height;
    assign m_any_vertex = head.any_vertex;
    assign m_last       = head.last;

endmodule

>>> src/vtgb_step.sv
// ----------------------------------------------------------------------------
// vtgb_step
// Varint assembly, command and delta decoding, cursor and box state.
// ----------------------------------------------------------------------------
module vtgb_step
    import vtgb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    output push_t      push
);

    logic [VTGB_ACC_W-1:0]   acc_reg, acc_next;
    logic [VTGB_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]             params_reg, params_next;
    logic                    expy_reg, expy_next;
    logic [31:0]             cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]             minx_reg, minx_next, maxx_reg, maxx_next;
    logic [31:0]             miny_reg, miny_next, maxy_reg, maxy_next;
    logic                    seen_reg, seen_next;

    logic [VTGB_ACC_W-1:0]   acc_v;
    logic [VTGB_ACC_W-1:0]   shifted;
    logic                    done;
    logic                    vtx_emit;
    logic                    fold_en;
    logic [31:0]             fminx, fmaxx, fminy, fmaxy;
    logic                    fseen;
    result_t                 vtx_res;
    result_t                 sum_res;

    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    shifted = VTGB_ACC_W'(data_byte & VTGB_PAYLOAD_MASK);
            3'd1:    shifted = VTGB_ACC_W'(data_byte & VTGB_PAYLOAD_MASK) << 7;
            3'd2:    shifted = VTGB_ACC_W'(data_byte & VTGB_PAYLOAD_MASK) << 14;
            3'd3:    shifted = VTGB_ACC_W'(data_byte & VTGB_PAYLOAD_MASK) << 21;
            3'd4:    shifted = VTGB_ACC_W'(data_byte & VTGB_PAYLOAD_MASK) << 28;
            default: shifted = '0;
        endcase
    end

    always_comb begin
        acc_v       = (cnt_reg < VTGB_GATHER_BYTES) ? (acc_reg | shifted) : acc_reg;
        done        = ((data_byte & VTGB_CONT_MASK) == 8'h00) ||
                      (cnt_reg >= VTGB_LAST_VARINT_BYTE) || end_of_buffer;
        acc_next    = acc_v;
        cnt_next    = cnt_reg + 1'b1;
        params_next = params_reg;
        expy_next   = expy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        vtx_emit    = 1'b0;

        if (done) begin
            acc_next = '0;
            cnt_next = '0;
            if (params_reg == 32'd0) begin
                case (cmd_id_t'(acc_v[2:0])) inside
                    CMD_MOVE_TO, CMD_LINE_TO: begin
                        params_next = acc_v[34:3];
                        expy_next   = 1'b0;
                    end
                    default: ;
                endcase
            end else if (!expy_reg) begin
                cx_next   = cx_reg + unzig(acc_v[31:0]);
                expy_next = 1'b1;
            end else begin
                cy_next     = cy_reg + unzig(acc_v[31:0]);
                expy_next   = 1'b0;
                params_next = params_reg - 32'd1;
                vtx_emit    = 1'b1;
            end
        end

        fold_en = vtx_emit || (end_of_buffer && (params_next != 32'd0));

        fminx = minx_reg;
        fmaxx = maxx_reg;
        fminy = miny_reg;
        fmaxy = maxy_reg;
        fseen = seen_reg;
        if (fold_en) begin
            fseen = 1'b1;
            if (!seen_reg) begin
                fminx = cx_next;
                fmaxx = cx_next;
                fminy = cy_next;
                fmaxy = cy_next;
            end else begin
                if ($signed(cx_next) < $signed(minx_reg)) fminx = cx_next;
                if ($signed(maxx_reg) < $signed(cx_next)) fmaxx = cx_next;
                if ($signed(cy_next) < $signed(miny_reg)) fminy = cy_next;
                if ($signed(maxy_reg) < $signed(cy_next)) fmaxy = cy_next;
            end
        end

        vtx_res            = '0;
        vtx_res.vertex_x   = cx_next;
        vtx_res.vertex_y   = cy_next;
        vtx_res.last       = !end_of_buffer;

        sum_res            = '0;
        sum_res.is_summary = 1'b1;
        sum_res.box_width  = fseen ? (fmaxx - fminx) : 32'd0;
        sum_res.box_height = fseen ? (fmaxy - fminy) : 32'd0;
        sum_res.any_vertex = fseen;
        sum_res.last       = 1'b1;

        push.n      = 2'(fold_en) + 2'(end_of_buffer);
        push.first  = fold_en ? vtx_res : sum_res;
        push.second = sum_res;
        if (!accept) begin
            push.n = 2'd0;
        end

        minx_next = fminx;
        maxx_next = fmaxx;
        miny_next = fminy;
        maxy_next = fmaxy;
        seen_next = fseen;

        if (end_of_buffer) begin
            acc_next    = '0;
            cnt_next    = '0;
            params_next = '0;
            expy_next   = 1'b0;
            cx_next     = '0;
            cy_next     = '0;
            minx_next   = '0;
            maxx_next   = '0;
            miny_next   = '0;
            maxy_next   = '0;
            seen_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            params_reg <= '0;
            expy_reg   <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            minx_reg   <= '0;
            maxx_reg   <= '0;
            miny_reg   <= '0;
            maxy_reg   <= '0;
            seen_reg   <= 1'b0;
        end else if (accept) begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            params_reg <= params_next;
            expy_reg   <= expy_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            minx_reg   <= minx_next;
            maxx_reg   <= maxx_next;
            miny_reg   <= miny_next;
            maxy_reg   <= maxy_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

>>> src/vtgb_queue.sv
// ----------------------------------------------------------------------------
// vtgb_queue
// Result queue taking up to two items per cycle and giving out one.
// ----------------------------------------------------------------------------
module vtgb_queue
    import vtgb_pkg::*;
#(
    parameter int unsigned DEPTH = VTGB_QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    not_empty,
    output result_t head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t            q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_second;

    assign wr_second = wr_reg + PTR_W'(1);
    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign not_empty = count_reg != '0;
    assign head      = q_reg[rd_reg];

    always_comb begin
        wr_next    = wr_reg + PTR_W'(push.n);
        rd_next    = pop ? rd_reg + PTR_W'(1) : rd_reg;
        count_next = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            q_reg[wr_second] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> src/vtgb_checker.sv
// ----------------------------------------------------------------------------
// vtgb_checker
// Port-level checks on the vector-tile geometry box block.
// ----------------------------------------------------------------------------
module vtgb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_is_summary,
    input logic signed [31:0] m_vertex_x,
    input logic signed [31:0] m_vertex_y,
    input logic [31:0]        m_box_width,
    input logic [31:0]        m_box_height,
    input logic               m_any_vertex,
    input logic               m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_summary) &&
            $stable(m_vertex_x) && $stable(m_vertex_y) && $stable(m_last))
        else $error("Result item changed while stalled.");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("Input held off with no result waiting.");

    a_vertex_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_summary |->
            m_box_width == 32'd0 && m_box_height == 32'd0 && !m_any_vertex)
        else $error("Vertex item carries box fields.");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_summary |->
            m_last && m_vertex_x == 32'sd0 && m_vertex_y == 32'sd0)
        else $error("Summary item is malformed.");

    a_empty_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_summary && !m_any_vertex |->
            m_box_width == 32'd0 && m_box_height == 32'd0)
        else $error("Empty buffer reported a non-zero box.");

endmodule

bind vector_tile_geometry_bbox vtgb_checker u_vtgb_checker (.*);

>>> bench/vector_tile_geometry_bbox_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_tile_geometry_bbox_tb
// Feeds the geometry decoder short directed buffers and then random buffers,
// mostly well-formed command streams with random content and the rest cut
// short or pure noise. A predictor decodes every accepted byte into the
// vertices and box summary it should cause, and each item on the result
// channel is compared field by field with the oldest prediction. Both
// channels stall at random in two of three phases, at differing pressure.
// ----------------------------------------------------------------------------
module vector_tile_geometry_bbox_tb;
    import vtgb_pkg::*;

    class bbox_scoreboard;
        result_t            due_results[$];
        result_t            fresh[$];
        int unsigned        errors;
        logic [34:0]        acc;
        logic [3:0]         acc_bytes;
        logic [31:0]        pairs_left;
        logic               want_y;
        logic signed [31:0] cur_x, cur_y, lo_x, hi_x, lo_y, hi_y;
        logic               have_vertex;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            acc         = '0;
            acc_bytes   = '0;
            pairs_left  = '0;
            want_y      = 1'b0;
            cur_x       = '0;
            cur_y       = '0;
            lo_x        = '0;
            hi_x        = '0;
            lo_y        = '0;
            hi_y        = '0;
            have_vertex = 1'b0;
        endfunction

        function logic [31:0] undo_zigzag(logic [31:0] z);
            return {1'b0, z[31:1]} ^ {32{z[0]}};
        endfunction

        function void emit_vertex();
            result_t r;
            if (!have_vertex) begin
                lo_x = cur_x;
                hi_x = cur_x;
                lo_y = cur_y;
                hi_y = cur_y;
                have_vertex = 1'b1;
            end else begin
                if (cur_x < lo_x) lo_x = cur_x;
                if (cur_x > hi_x) hi_x = cur_x;
                if (cur_y < lo_y) lo_y = cur_y;
                if (cur_y > hi_y) hi_y = cur_y;
            end
            r = '0;
            r.vertex_x = cur_x;
            r.vertex_y = cur_y;
            fresh.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic eob);
            logic [34:0] v;
            logic        done;
            result_t     r;
            fresh.delete();
            if (acc_bytes < VTGB_GATHER_BYTES)
                acc = acc | (35'(b & VTGB_PAYLOAD_MASK) << (7 * acc_bytes));
            acc_bytes = acc_bytes + 4'd1;
            done = ((b & VTGB_CONT_MASK) == 8'd0) || acc_bytes > VTGB_LAST_VARINT_BYTE || eob;
            if (done) begin
                v = acc;
                acc = '0;
                acc_bytes = '0;
                if (pairs_left == 0) begin
                    if (cmd_id_t'(v[2:0]) == CMD_MOVE_TO || cmd_id_t'(v[2:0]) == CMD_LINE_TO) begin
                        pairs_left = v[34:3];
                        want_y = 1'b0;
                    end
                end else if (!want_y) begin
                    cur_x = cur_x + undo_zigzag(v[31:0]);
                    want_y = 1'b1;
                end else begin
                    cur_y = cur_y + undo_zigzag(v[31:0]);
                    want_y = 1'b0;
                    pairs_left = pairs_left - 1;
                    emit_vertex();
                end
            end
            if (eob) begin
                if (pairs_left != 0 && fresh.size() == 0)
                    emit_vertex();
                r = '0;
                r.is_summary = 1'b1;
                r.box_width  = have_vertex ? 32'(hi_x - lo_x) : 32'd0;
                r.box_height = have_vertex ? 32'(hi_y - lo_y) : 32'd0;
                r.any_vertex = have_vertex;
                fresh.push_back(r);
                clear_state();
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                due_results.push_back(fresh[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                $error("result item arrived with nothing predicted");
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("is_summary", want.is_summary, got.is_summary);
            compare_field("vertex_x", want.vertex_x, got.vertex_x);
            compare_field("vertex_y", want.vertex_y, got.vertex_y);
            compare_field("box_width", want.box_width, got.box_width);
            compare_field("box_height", want.box_height, got.box_height);
            compare_field("any_vertex", want.any_vertex, got.any_vertex);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_data_byte;
    logic               s_end_of_buffer;
    logic               m_valid;
    logic               m_ready;
    logic               m_is_summary;
    logic signed [31:0] m_vertex_x;
    logic signed [31:0] m_vertex_y;
    logic [31:0]        m_box_width;
    logic [31:0]        m_box_height;
    logic               m_any_vertex;
    logic               m_last;

    bbox_scoreboard sb;
    logic [7:0]     geom[$];
    int             src_idle_pct;
    int             dst_idle_pct;
    int             sent_bytes;

    vector_tile_geometry_bbox uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_summary    (m_is_summary),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_box_width     (m_box_width),
        .m_box_height    (m_box_height),
        .m_any_vertex    (m_any_vertex),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && s_valid && s_ready)
            sb.take_byte(s_data_byte, s_end_of_buffer);
        if (aresetn && m_valid && m_ready) begin
            got.is_summary = m_is_summary;
            got.vertex_x   = m_vertex_x;
            got.vertex_y   = m_vertex_y;
            got.box_width  = m_box_width;
            got.box_height = m_box_height;
            got.any_vertex = m_any_vertex;
            got.last       = m_last;
            sb.check_result(got);
        end
    end

    function automatic int pick_pad();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(4, 7);
    endfunction

    // Padding bytes make the encoding longer than needed; bytes past the
    // fifth may carry payload that the block must drop.
    function automatic void put_varint(logic [34:0] v, int pad);
        int         need;
        int         total;
        logic [6:0] part;
        need = 1;
        while (need < 5 && (v >> (7 * need)) != 0)
            need++;
        total = need + pad;
        for (int i = 0; i < total; i++) begin
            if (i < 5)
                part = v[7 * i +: 7];
            else
                part = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'd0;
            geom.push_back({(i < total - 1) ? 1'b1 : 1'b0, part});
        end
    endfunction

    function automatic void put_delta();
        logic [31:0] d;
        logic [31:0] z;
        logic [2:0]  top;
        int          r;
        r = $urandom_range(99);
        if (r < 50)
            d = 32'($urandom_range(40)) - 32'd20;
        else if (r < 85)
            d = $urandom;
        else if (r < 90)
            d = 32'h7fffffff;
        else if (r < 95)
            d = 32'h80000000;
        else
            d = 32'd0;
        z = (d << 1) ^ {32{d[31]}};
        top = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd0;
        put_varint({top, z}, pick_pad());
    endfunction

    function automatic void build_buffer();
        int          kind;
        int          r;
        int          npairs;
        logic        stop;
        cmd_id_t     id;
        logic [31:0] count;
        geom.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 8)) geom.push_back(8'($urandom_range(255)));
        end else begin
            stop = 1'b0;
            repeat ($urandom_range(1, 4)) begin
                if (!stop) begin
                    if ($urandom_range(99) < 75)
                        id = cmd_id_t'($urandom_range(CMD_MOVE_TO, CMD_LINE_TO));
                    else
                        id = cmd_id_t'($urandom_range(7));
                    r = $urandom_range(99);
                    if (r < 80)
                        count = $urandom_range(0, 4);
                    else if (r < 95)
                        count = $urandom_range(5, 8);
                    else
                        count = $urandom;
                    put_varint({count, id}, pick_pad());
                    if (id == CMD_MOVE_TO || id == CMD_LINE_TO) begin
                        npairs = (count > 8) ? $urandom_range(0, 3) : int'(count);
                        stop = (count > 8);
                        repeat (npairs) begin
                            put_delta();
                            put_delta();
                        end
                    end
                end
            end
            if (kind < 30 && geom.size() > 1)
                geom = geom[0:$urandom_range(0, geom.size() - 2)];
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_buffer <= eob;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_bytes++;
    endtask

    task automatic send_buffer();
        foreach (geom[i])
            send_byte(geom[i], i == geom.size() - 1);
    endtask

    initial begin
        int waited;
        s_valid         = 1'b0;
        s_data_byte     = 8'd0;
        s_end_of_buffer = 1'b0;
        m_ready         = 1'b0;
        aresetn         = 1'b0;
        src_idle_pct    = 8;
        dst_idle_pct    = 72;
        sent_bytes      = 0;
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A lone empty command, then one vertex at the far corners of the
        // coordinate range closed by its own final byte.
        geom = '{8'h00};
        send_buffer();
        geom = '{8'h09, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f,
                 8'hfe, 8'hff, 8'hff, 8'hff, 8'h0f};
        send_buffer();
        // A ten-byte command with dropped high bits and a huge count, ended
        // after only the x delta.
        geom = '{8'h81, 8'h81, 8'h81, 8'h81, 8'h81,
                 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h03};
        send_buffer();
        // A LineTo with no deltas at all, and a LineTo whose y delta is cut
        // off mid-varint.
        geom = '{8'h0a};
        send_buffer();
        geom = '{8'h12, 8'h03, 8'h81};
        send_buffer();
        geom = '{8'h0f};
        send_buffer();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 72 : 0;
            dst_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 8 : 0;
            while (sent_bytes < 30 + (phase + 1) * 610) begin
                build_buffer();
                send_buffer();
            end
        end
        s_valid <= 1'b0;

        waited = 0;
        while (sb.due_results.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (32) @(negedge aclk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("vector_tile_geometry_bbox verification clean");
        end else begin
            $display("vector_tile_geometry_bbox verification failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("vector_tile_geometry_bbox verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/vtgb_pkg.sv
src/vtgb_step.sv
src/vtgb_queue.sv
src/vector_tile_geometry_bbox.sv
src/vtgb_checker.sv
bench/vector_tile_geometry_bbox_tb.sv
